// ----- rtl/addressed_command_frame_receiver_defines.svh -----
// Assertion macros shared by the checker of the command frame receiver.
// No dependencies; included by the files that hold assertions.
`ifndef ADDRESSED_COMMAND_FRAME_RECEIVER_DEFINES_SVH
`define ADDRESSED_COMMAND_FRAME_RECEIVER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define ACFR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ACFR_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ACFR_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- rtl/acfr_pkg.sv -----
// Types and constants of the addressed command frame receiver.
// No dependencies; imported by every module of the block.
package acfr_pkg;

	// Host event and received byte codes.
	localparam logic [1:0] OP_RX_BYTE   = 2'd0;
	localparam logic [1:0] OP_BEGIN     = 2'd1;
	localparam logic [1:0] OP_END       = 2'd2;
	localparam logic [1:0] OP_POP       = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_OWN_ADDR   = 1'b0;
	localparam logic CFG_BCAST_ADDR = 1'b1;

	// Framing characters.
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_BANG   = 8'h21;

	// Command buffer geometry; the depth is a power of two.
	localparam int BUF_DEPTH = 64;
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = 7;

	// Queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [15:0] DROP_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_valid;
		logic        byte_stored;
		logic        command_ready;
		logic        unit_addressed;
		logic        broadcast_command;
		logic        busy_processing;
		logic        overload_seen;
		logic [6:0]  fill_level;
		logic [15:0] overflow_count;
	} rsp_t;

	// A classified item as it sits in the queue.
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
		logic       is_dollar;
		logic       is_bang;
		logic       own_hit;
		logic       bcast_hit;
	} item_t;

endpackage

// ----- rtl/acfr_front.sv -----
// Front part of the command frame receiver: classifies beats and queues them.
// Depends on acfr_pkg.
module acfr_front import acfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] own_addr,
	input  logic [7:0] bcast_addr,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       q_valid,
	output item_t      q_head,
	input  logic       q_deq
);

	item_t             item_d;
	item_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              enq;
	logic              deq;

	// Classify the incoming byte against the framing characters and addresses.
	always_comb begin
		item_d.opcode    = cmd.opcode;
		item_d.rx_byte   = cmd.rx_byte;
		item_d.is_dollar = (cmd.rx_byte == CHAR_DOLLAR);
		item_d.is_bang   = (cmd.rx_byte == CHAR_BANG);
		item_d.own_hit   = (cmd.rx_byte == own_addr);
		item_d.bcast_hit = (cmd.rx_byte == bcast_addr);
	end

	assign cmd_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign enq       = cmd_valid && cmd_ready;
	assign q_valid   = (cnt_q != '0);
	assign deq       = q_deq && q_valid;
	assign q_head    = ent_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[wr_ptr_q] <= item_d;
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/acfr_back.sv -----
// Back part of the command frame receiver: framing state, command buffer
// memory and the response register. Depends on acfr_pkg.
module acfr_back import acfr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  item_t q_head,
	output logic  q_deq,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);

	logic [7:0]       mem_q [BUF_DEPTH];
	logic             expect_q, addressed_q, bcast_q, ready_q, proc_q, overload_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      drop_q;

	logic             expect_d, addressed_d, bcast_d, ready_d, proc_d, overload_d;
	logic [PTR_W-1:0] rp_d;
	logic [CNT_W-1:0] cnt_d;
	logic [15:0]      drop_d;
	logic             take;
	logic             wr_en;
	logic             pop_ok;
	logic [PTR_W-1:0] wr_slot;
	logic             buf_full;
	rsp_t             rsp_d;
	rsp_t             rsp_s2;
	logic [7:0]       rdata_s2;
	logic             valid_s2;

	assign take     = q_valid && (!valid_s2 || rsp_ready);
	assign q_deq    = take;
	assign buf_full = (cnt_q == CNT_W'(BUF_DEPTH));
	assign wr_slot  = rp_q + cnt_q[PTR_W-1:0];

	// Next framing state for the item at the head of the queue.
	always_comb begin
		expect_d    = expect_q;
		addressed_d = addressed_q;
		bcast_d     = bcast_q;
		ready_d     = ready_q;
		proc_d      = proc_q;
		overload_d  = overload_q;
		rp_d        = rp_q;
		cnt_d       = cnt_q;
		drop_d      = drop_q;
		wr_en       = 1'b0;
		pop_ok      = 1'b0;
		unique case (q_head.opcode)
			OP_RX_BYTE: begin
				if (!expect_q) begin
					if (q_head.is_dollar && addressed_q) begin
						// End of frame: the dollar itself is not stored.
						ready_d     = 1'b1;
						addressed_d = 1'b0;
					end else begin
						if (q_head.is_bang) begin
							expect_d = 1'b1;
						end
						if (addressed_q) begin
							if (buf_full) begin
								if (drop_q != DROP_MAX) begin
									drop_d = drop_q + 16'd1;
								end
							end else begin
								wr_en = 1'b1;
								cnt_d = cnt_q + 1'b1;
							end
						end
					end
				end else begin
					// Address byte after a bang.
					expect_d = 1'b0;
					if (q_head.own_hit) begin
						if (proc_q) begin
							overload_d = 1'b1;
							rp_d       = '0;
							cnt_d      = '0;
							bcast_d    = 1'b0;
							proc_d     = 1'b0;
						end
						addressed_d = 1'b1;
					end
					if (q_head.bcast_hit) begin
						bcast_d     = 1'b1;
						addressed_d = 1'b1;
					end
				end
			end
			OP_BEGIN: begin
				proc_d  = 1'b1;
				ready_d = 1'b0;
			end
			OP_END: begin
				rp_d    = '0;
				cnt_d   = '0;
				bcast_d = 1'b0;
				proc_d  = 1'b0;
			end
			OP_POP: begin
				if (cnt_q != '0) begin
					pop_ok = 1'b1;
					rp_d   = rp_q + 1'b1;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Response fields other than the read data, which comes from the memory.
	always_comb begin
		rsp_d.read_data         = '0;
		rsp_d.read_valid        = pop_ok;
		rsp_d.byte_stored       = wr_en;
		rsp_d.command_ready     = ready_d;
		rsp_d.unit_addressed    = addressed_d;
		rsp_d.broadcast_command = bcast_d;
		rsp_d.busy_processing   = proc_d;
		rsp_d.overload_seen     = overload_d;
		rsp_d.fill_level        = cnt_d;
		rsp_d.overflow_count    = drop_d;
	end

	// Command buffer write port.
	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			mem_q[wr_slot] <= q_head.rx_byte;
		end
	end

	// Response register with the registered buffer read.
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_s2 <= rsp_d;
			if (pop_ok) begin
				rdata_s2 <= mem_q[rp_q];
			end else begin
				rdata_s2 <= 8'd0;
			end
		end
	end

	// Framing state and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q    <= 1'b0;
			addressed_q <= 1'b0;
			bcast_q     <= 1'b0;
			ready_q     <= 1'b0;
			proc_q      <= 1'b0;
			overload_q  <= 1'b0;
			rp_q        <= '0;
			cnt_q       <= '0;
			drop_q      <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (take) begin
				expect_q    <= expect_d;
				addressed_q <= addressed_d;
				bcast_q     <= bcast_d;
				ready_q     <= ready_d;
				proc_q      <= proc_d;
				overload_q  <= overload_d;
				rp_q        <= rp_d;
				cnt_q       <= cnt_d;
				drop_q      <= drop_d;
				valid_s2    <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign rsp_valid = valid_s2;

	// The read data joins the other response fields at the port.
	always_comb begin
		rsp           = rsp_s2;
		rsp.read_data = rdata_s2;
	end

endmodule

// ----- rtl/addressed_command_frame_receiver.sv -----
// Top level of the addressed command frame receiver.
// Depends on acfr_pkg, acfr_front and acfr_back.

// Multidrop command receiver: takes one beat per clock while cmd_ready is high,
// either a received bus byte or a host event, and returns exactly one response
// beat for each. The sustained rate is one beat per cycle when nothing stalls,
// set by the framing update in the back part and its one write port plus one
// registered read port on the 64-byte command buffer. A beat's response goes
// through the queue and then the response register; the two-entry queue between
// the classifier and the framing logic lets either side stall on its own. The
// address registers may only be written while no beat is in flight.
module addressed_command_frame_receiver import acfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	logic [7:0] own_addr_q;
	logic [7:0] bcast_addr_q;
	logic       q_valid;
	logic       q_deq;
	item_t      q_head;

	// Address registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q   <= 8'd1;
			bcast_addr_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_ADDR:   own_addr_q   <= cfg_data;
				CFG_BCAST_ADDR: bcast_addr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	acfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.own_addr   (own_addr_q),
		.bcast_addr (bcast_addr_q),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_deq      (q_deq)
	);

	acfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_deq     (q_deq),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/acfr_checker.sv -----
// Port-level checker for the addressed command frame receiver, with its bind.
// Depends on acfr_pkg and addressed_command_frame_receiver_defines.svh.
`include "addressed_command_frame_receiver_defines.svh"

module acfr_checker import acfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input rsp_t       rsp
);

	// A stalled response beat holds.
	`ACFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response beat changed while stalled")

	// The buffer never holds more than its depth.
	`ACFR_ASSERT_ALWAYS(a_fill_bound, !rsp_valid || rsp.fill_level <= CNT_W'(BUF_DEPTH), "fill level above buffer depth")

	// A pop and an append never come from the same beat.
	`ACFR_ASSERT_SAME(a_pop_xor_store, rsp_valid && rsp.read_valid, !rsp.byte_stored, "pop and store in one beat")

	// Read data is zero unless a pop returned a byte.
	`ACFR_ASSERT_SAME(a_rdata_zero, rsp_valid && !rsp.read_valid, rsp.read_data == 8'd0, "read data without a pop")

	// A stored byte leaves the buffer non-empty.
	`ACFR_ASSERT_SAME(a_store_fill, rsp_valid && rsp.byte_stored, rsp.fill_level != 7'd0, "stored byte with empty buffer")

endmodule

bind addressed_command_frame_receiver acfr_checker u_acfr_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for the addressed command frame receiver.
// Depends on acfr_pkg and the addressed_command_frame_receiver top level.
// Beats are predicted by a local copy of the framing logic, then compared field by field.
module testbench;
	import acfr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       cmd_valid;
	logic       cmd_ready;
	cmd_t       cmd;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;

	// Local copy of the receiver state and its address settings.
	logic [7:0]  own_addr_cfg;
	logic [7:0]  bcast_addr_cfg;
	logic        want_address;
	logic        addressed;
	logic        from_bcast;
	logic        frame_done;
	logic        processing;
	logic        overload;
	logic [7:0]  frame_mem [BUF_DEPTH];
	logic [5:0]  head;
	logic [6:0]  fill;
	logic [15:0] dropped;

	// Beats waiting to be sent and status beats still owed by the block.
	cmd_t beats_to_send [$];
	rsp_t status_due [$];

	int cmds_queued;
	int cmds_sent;
	int status_seen;
	int mismatches;
	int settings_used;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int hold_acks;
	int hold_left;

	addressed_command_frame_receiver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Free-running clock, period of 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Appends one byte to the circular command buffer, or counts it as dropped.
	function automatic logic store_byte(input logic [7:0] b);
		logic [5:0] slot;
		if (fill == 7'(BUF_DEPTH)) begin
			if (dropped != DROP_MAX)
				dropped = dropped + 16'd1;
			return 1'b0;
		end
		slot = head + fill[5:0];
		frame_mem[slot] = b;
		fill = fill + 7'd1;
		return 1'b1;
	endfunction

	// Works out the status beat for one command beat and advances the local state.
	function automatic rsp_t predict_status(input cmd_t c);
		rsp_t r;
		r = '0;
		case (c.opcode)
			OP_RX_BYTE: begin
				if (!want_address) begin
					if (c.rx_byte == CHAR_DOLLAR && addressed) begin
						frame_done = 1'b1;
						addressed = 1'b0;
					end else if (c.rx_byte == CHAR_BANG) begin
						want_address = 1'b1;
					end
					if (addressed)
						r.byte_stored = store_byte(c.rx_byte);
				end else begin
					want_address = 1'b0;
					if (c.rx_byte == own_addr_cfg) begin
						// Addressed again while the host is busy: abort the command.
						if (processing) begin
							overload = 1'b1;
							head = '0;
							fill = '0;
							from_bcast = 1'b0;
							processing = 1'b0;
						end
						addressed = 1'b1;
					end
					if (c.rx_byte == bcast_addr_cfg) begin
						from_bcast = 1'b1;
						addressed = 1'b1;
					end
				end
			end
			OP_BEGIN: begin
				processing = 1'b1;
				frame_done = 1'b0;
			end
			OP_END: begin
				head = '0;
				fill = '0;
				from_bcast = 1'b0;
				processing = 1'b0;
			end
			default: begin
				if (fill != '0) begin
					r.read_data = frame_mem[head];
					r.read_valid = 1'b1;
					head = head + 6'd1;
					fill = fill - 7'd1;
				end
			end
		endcase
		r.command_ready = frame_done;
		r.unit_addressed = addressed;
		r.broadcast_command = from_bcast;
		r.busy_processing = processing;
		r.overload_seen = overload;
		r.fill_level = fill;
		r.overflow_count = dropped;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Driver: offers the next pending beat and predicts each accepted one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				status_due.push_back(predict_status(cmd));
				cmds_sent++;
			end
			if (!cmd_valid || cmd_ready) begin
				if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd <= beats_to_send.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_acks != hold_requests) begin
			hold_left = HOLD_CYCLES;
			hold_acks = hold_requests;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: compares each accepted status beat with the oldest prediction.
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (status_due.size() == 0) begin
				$error("status beat arrived with no command outstanding");
				mismatches++;
			end else begin
				want = status_due.pop_front();
				status_seen++;
				check_field("read_data", 32'(want.read_data), 32'(rsp.read_data));
				check_field("read_valid", 32'(want.read_valid), 32'(rsp.read_valid));
				check_field("byte_stored", 32'(want.byte_stored), 32'(rsp.byte_stored));
				check_field("command_ready", 32'(want.command_ready),
					32'(rsp.command_ready));
				check_field("unit_addressed", 32'(want.unit_addressed),
					32'(rsp.unit_addressed));
				check_field("broadcast_command", 32'(want.broadcast_command),
					32'(rsp.broadcast_command));
				check_field("busy_processing", 32'(want.busy_processing),
					32'(rsp.busy_processing));
				check_field("overload_seen", 32'(want.overload_seen),
					32'(rsp.overload_seen));
				check_field("fill_level", 32'(want.fill_level), 32'(rsp.fill_level));
				check_field("overflow_count", 32'(want.overflow_count),
					32'(rsp.overflow_count));
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL addressed_command_frame_receiver");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [1:0] op, input logic [7:0] b);
		cmd_t c;
		c.opcode = op;
		c.rx_byte = b;
		beats_to_send.push_back(c);
		cmds_queued++;
	endtask

	// Waits until every beat has been sent and answered, then lets the pipe settle.
	task automatic wait_until_drained();
		do
			@(posedge clk);
		while (beats_to_send.size() != 0 || cmd_valid || status_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OWN_ADDR)
			own_addr_cfg = val;
		else
			bcast_addr_cfg = val;
	endtask

	// Payload byte of a frame; a dollar sign only rarely ends a frame early.
	function automatic logic [7:0] payload_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CHAR_DOLLAR && $urandom_range(9) != 0)
			b = b ^ 8'h01;
		return b;
	endfunction

	// One addressed frame: bang, address, payload and, usually, the closing dollar.
	task automatic queue_frame(input bit terminate);
		int pick;
		int len;
		logic [7:0] addr;
		pick = $urandom_range(99);
		if (pick < 45)
			addr = own_addr_cfg;
		else if (pick < 70)
			addr = bcast_addr_cfg;
		else
			addr = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 85)
			len = $urandom_range(8);
		else if (pick < 95)
			len = $urandom_range(40, 9);
		else
			len = $urandom_range(72, 60);
		queue_cmd(OP_RX_BYTE, CHAR_BANG);
		queue_cmd(OP_RX_BYTE, addr);
		repeat (len) queue_cmd(OP_RX_BYTE, payload_byte());
		if (terminate)
			queue_cmd(OP_RX_BYTE, CHAR_DOLLAR);
	endtask

	// A frame followed by host activity, or a short burst of noise.
	task automatic queue_session();
		int pick;
		pick = $urandom_range(99);
		if (pick < 12) begin
			repeat ($urandom_range(4, 1))
				queue_cmd(2'($urandom_range(3)), 8'($urandom_range(255)));
		end else begin
			queue_frame(pick >= 20);
			if ($urandom_range(99) < 70) begin
				queue_cmd(OP_BEGIN, 8'($urandom_range(255)));
				repeat ($urandom_range(10)) queue_cmd(OP_POP, 8'($urandom_range(255)));
				// Sometimes the unit is addressed again before the host is done.
				if ($urandom_range(99) < 20)
					queue_frame(1'b1);
				if ($urandom_range(99) < 85)
					queue_cmd(OP_END, 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(4)) queue_cmd(OP_POP, 8'($urandom_range(255)));
			end
		end
	endtask

	// One random phase under a given address setting and idling mix.
	task automatic run_phase(input logic [7:0] own, input logic [7:0] bcast,
			input int send_pct, input int stall_pct, input int items, input bit hold);
		int goal;
		wait_until_drained();
		write_reg(CFG_OWN_ADDR, own);
		write_reg(CFG_BCAST_ADDR, bcast);
		settings_used++;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		goal = cmds_queued + items;
		while (cmds_queued < goal)
			queue_session();
		if (hold)
			hold_requests++;
	endtask

	// Directed beats, random phases, then an overlong frame that overflows the buffer.
	initial begin : stimulus
		logic [7:0] own_pick;
		logic [7:0] fill_byte;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_ready = 1'b0;
		own_addr_cfg = 8'd1;
		bcast_addr_cfg = 8'd0;
		want_address = 1'b0;
		addressed = 1'b0;
		from_bcast = 1'b0;
		frame_done = 1'b0;
		processing = 1'b0;
		overload = 1'b0;
		head = '0;
		fill = '0;
		dropped = '0;
		cmds_queued = 0;
		cmds_sent = 0;
		status_seen = 0;
		mismatches = 0;
		settings_used = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests = 0;
		hold_acks = 0;
		hold_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the own address at its top and broadcast at zero.
		write_reg(CFG_OWN_ADDR, 8'hFF);
		write_reg(CFG_BCAST_ADDR, 8'h00);
		settings_used++;
		queue_cmd(OP_POP, 8'hFF);                 // pop on an empty buffer
		queue_cmd(OP_RX_BYTE, CHAR_DOLLAR);       // dollar while not addressed
		queue_cmd(OP_RX_BYTE, CHAR_BANG);
		queue_cmd(OP_RX_BYTE, 8'h33);             // address that matches nothing
		queue_cmd(OP_RX_BYTE, CHAR_BANG);
		queue_cmd(OP_RX_BYTE, 8'hFF);             // own address
		queue_cmd(OP_RX_BYTE, 8'h00);
		queue_cmd(OP_RX_BYTE, 8'hFF);
		queue_cmd(OP_RX_BYTE, CHAR_BANG);         // bang while addressed is stored
		queue_cmd(OP_RX_BYTE, 8'h00);             // taken as the broadcast address
		queue_cmd(OP_RX_BYTE, 8'h55);
		queue_cmd(OP_RX_BYTE, CHAR_DOLLAR);
		queue_cmd(OP_BEGIN, 8'h00);
		queue_cmd(OP_RX_BYTE, CHAR_BANG);
		queue_cmd(OP_RX_BYTE, 8'hFF);             // own address during processing
		queue_cmd(OP_RX_BYTE, 8'hA5);
		queue_cmd(OP_RX_BYTE, CHAR_DOLLAR);
		queue_cmd(OP_POP, 8'h00);
		queue_cmd(OP_POP, 8'h00);
		queue_cmd(OP_BEGIN, 8'hFF);
		queue_cmd(OP_RX_BYTE, CHAR_BANG);
		queue_cmd(OP_RX_BYTE, 8'h00);             // broadcast during processing
		queue_cmd(OP_RX_BYTE, 8'h7E);
		queue_cmd(OP_END, 8'hFF);
		queue_cmd(OP_POP, 8'h00);

		run_phase(8'd1, 8'd0, 0, 0, 110, 1'b0);
		run_phase(8'hFF, 8'hFF, 73, 0, 110, 1'b0);         // own equals broadcast
		run_phase(8'h00, CHAR_DOLLAR, 0, 73, 110, 1'b0);   // own written as zero
		run_phase(8'($urandom_range(255, 1)), 8'($urandom_range(255)), 36, 36, 110, 1'b0);
		run_phase(8'($urandom_range(255, 1)), CHAR_BANG, 0, 0, 110, 1'b1);
		own_pick = 8'($urandom_range(255, 1));
		run_phase(own_pick, own_pick, 36, 36, 110, 1'b0);

		// Overflow run: one frame longer than the buffer so that bytes are dropped.
		wait_until_drained();
		own_pick = 8'($urandom_range(255, 1));
		write_reg(CFG_OWN_ADDR, own_pick);
		write_reg(CFG_BCAST_ADDR, own_pick ^ 8'h5A);
		settings_used++;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_cmd(OP_RX_BYTE, CHAR_BANG);
		queue_cmd(OP_RX_BYTE, own_pick);
		repeat (75) begin
			fill_byte = 8'($urandom_range(255));
			if (fill_byte == CHAR_BANG || fill_byte == CHAR_DOLLAR)
				fill_byte = fill_byte ^ 8'h80;
			queue_cmd(OP_RX_BYTE, fill_byte);
		end
		queue_cmd(OP_RX_BYTE, CHAR_DOLLAR);
		queue_cmd(OP_BEGIN, 8'h00);
		repeat (3) queue_cmd(OP_POP, 8'h00);
		queue_cmd(OP_END, 8'h00);

		wait_until_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d command beats, checked %0d status beats over %0d address settings.",
			cmds_sent, status_seen, settings_used);
		$display("Drop counter finished at %0d; %0d field mismatches.", dropped, mismatches);
		if (mismatches == 0 && status_due.size() == 0) begin
			$display("PASS addressed_command_frame_receiver");
		end else begin
			$display("FAIL addressed_command_frame_receiver");
		end
		$finish;
	end

endmodule
